/* src/puct_child_selector_assert.svh */
// Assertion macros used by the selector's top-level RTL file.
`ifndef PUCT_CHILD_SELECTOR_ASSERT_SVH
`define PUCT_CHILD_SELECTOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PCS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PCS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/pcs_pkg.sv */
// ----------------------------------------------------------------------------
// PUCT child selector package
// Field widths, register codes, constants and the types shared between the
// front end, the scoring back end and the top level.
// ----------------------------------------------------------------------------
package pcs_pkg;

    localparam int VisitW  = 20;
    localparam int ActW    = 16;
    localparam int TotalW  = 37;
    localparam int PriorW  = 17;
    localparam int ScoreW  = 32;
    localparam int BaseW   = 24;
    localparam int InitW   = 20;
    localparam int CfgIdxW = 8;
    localparam int CfgDatW = 24;
    localparam int FracW   = 16;

    // Register indices of the configuration port
    localparam logic [CfgIdxW-1:0] REG_C_BASE = 8'd0;
    localparam logic [CfgIdxW-1:0] REG_C_INIT = 8'd1;

    localparam logic [BaseW-1:0] C_BASE_RST = 24'd503091;
    localparam logic [InitW-1:0] C_INIT_RST = 20'd81920;

    // ln(2) in Q32
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    // Item as held in the queue, already classified by the front end
    typedef struct packed {
        logic [VisitW-1:0] pv;       // parent visits, zero taken as one
        logic [ActW-1:0]   action;
        logic [VisitW-1:0] n;        // child visits
        logic              n_zero;
        logic              neg;      // total value is negative
        logic [TotalW-1:0] mag;      // magnitude of total value
        logic [PriorW-1:0] prior;
        logic              last;
    } t_item;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    typedef struct packed {
        logic pop;   // back end takes the queue head
        logic done;  // result beat loaded into the output register
    } t_back_stat;

endpackage

/* src/pcs_if.sv */
// ----------------------------------------------------------------------------
// PUCT child selector channels
// Valid/ready channels for child items, results and configuration writes.
// ----------------------------------------------------------------------------
interface pcs_in_if;
    import pcs_pkg::*;
    logic                valid;
    logic                ready;
    logic [VisitW-1:0]   node_visits;
    logic [ActW-1:0]     move_action;
    logic [VisitW-1:0]   child_visits;
    logic signed [TotalW-1:0] child_total_value;
    logic [PriorW-1:0]   prior_prob;
    logic                last_child;

    modport source (output valid, node_visits, move_action, child_visits,
                    child_total_value, prior_prob, last_child, input ready);
    modport sink   (input valid, node_visits, move_action, child_visits,
                    child_total_value, prior_prob, last_child, output ready);
endinterface

interface pcs_out_if;
    import pcs_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [ActW-1:0]          best_action;
    logic signed [ScoreW-1:0] best_score;

    modport source (output valid, best_action, best_score, input ready);
    modport sink   (input valid, best_action, best_score, output ready);
endinterface

interface pcs_cfg_if;
    import pcs_pkg::*;
    logic               valid;
    logic               ready;
    logic [CfgIdxW-1:0] index;
    logic [CfgDatW-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* src/pcs_front.sv */
// ----------------------------------------------------------------------------
// PUCT child selector front end
// Accepts child beats, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module pcs_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    pcs_in_if.sink              i_in,
    input  pcs_pkg::t_back_stat i_bk,
    output pcs_pkg::t_item      o_head,
    output pcs_pkg::t_q_stat    o_stat
);
    import pcs_pkg::*;

    t_item      r_mem [2];
    logic [1:0] r_cnt, n_cnt;
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic       push;
    logic       pop;
    t_item      cls;

    // Classify the incoming beat
    always_comb begin
        cls.pv     = (i_in.node_visits == '0) ? VisitW'(1) : i_in.node_visits;
        cls.action = i_in.move_action;
        cls.n      = i_in.child_visits;
        cls.n_zero = (i_in.child_visits == '0);
        cls.neg    = i_in.child_total_value[TotalW-1];
        cls.mag    = cls.neg ? (~i_in.child_total_value + TotalW'(1))
                             : i_in.child_total_value;
        cls.prior  = i_in.prior_prob;
        cls.last   = i_in.last_child;
    end

    assign i_in.ready   = (r_cnt != 2'd2);
    assign push         = i_in.valid && i_in.ready;
    assign pop          = i_bk.pop;
    assign o_head       = r_mem[r_rp];
    assign o_stat.empty = (r_cnt == 2'd0);
    assign o_stat.full  = (r_cnt == 2'd2);

    // Advance pointers and count
    always_comb begin
        n_wp  = push ? ~r_wp : r_wp;
        n_rp  = pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + (push ? 2'd1 : 2'd0) - (pop ? 2'd1 : 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_wp  <= n_wp;
            r_rp  <= n_rp;
        end
    end

    // Store the beat
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= cls;
        end
    end

endmodule

/* src/pcs_back.sv */
// ----------------------------------------------------------------------------
// PUCT child selector back end
// Scores one child at a time with a shared bit-serial divider, a squaring
// loop for the logarithm and a digit-serial square root, then keeps the best.
// ----------------------------------------------------------------------------
module pcs_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pcs_pkg::t_item                i_head,
    input  pcs_pkg::t_q_stat              i_stat,
    input  logic [pcs_pkg::BaseW-1:0]     i_c_base,
    input  logic [pcs_pkg::InitW-1:0]     i_c_init,
    output pcs_pkg::t_back_stat           o_bk,
    pcs_out_if.source                     o_res
);
    import pcs_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_MEAN  = 12'b0000_0000_0010,
        S_LNDIV = 12'b0000_0000_0100,
        S_NORM  = 12'b0000_0000_1000,
        S_SQ    = 12'b0000_0001_0000,
        S_SQN   = 12'b0000_0010_0000,
        S_LNMUL = 12'b0000_0100_0000,
        S_CP    = 12'b0000_1000_0000,
        S_SQRT  = 12'b0001_0000_0000,
        S_UMUL  = 12'b0010_0000_0000,
        S_UDIV  = 12'b0100_0000_0000,
        S_SCORE = 12'b1000_0000_0000
    } t_state;

    t_state r_st, n_st;
    t_item  r_it, n_it;
    logic [5:0]  r_cnt, n_cnt;
    // divider
    logic [63:0] r_dvd, n_dvd;
    logic [23:0] r_rem, n_rem;
    logic [23:0] r_dvs, n_dvs;
    // logarithm
    logic [63:0] r_r, n_r;
    logic [30:0] r_m, n_m;
    logic [61:0] r_prod, n_prod;
    logic [4:0]  r_ip, n_ip;
    logic [19:0] r_frac, n_frac;
    logic [56:0] r_lnp, n_lnp;
    logic [22:0] r_cp, n_cp;
    // square root
    logic [52:0] r_sx, n_sx;
    logic [52:0] r_sr, n_sr;
    logic [52:0] r_sb, n_sb;
    logic [25:0] r_s, n_s;
    // score
    logic [36:0] r_mean, n_mean;
    logic [48:0] r_uq, n_uq;
    logic signed [ScoreW-1:0] r_best, n_best;
    logic [ActW-1:0] r_bact, n_bact;
    logic r_open, n_open;
    // output register
    logic r_ovalid, n_ovalid;
    logic [ActW-1:0] r_oact, n_oact;
    logic signed [ScoreW-1:0] r_oscore, n_oscore;

    // combinational helpers
    logic [24:0] rem_sh, rem_df;
    logic        q_bit;
    logic [63:0] q_next;
    logic [28:0] a_val;
    logic [23:0] b_val;
    logic [31:0] mq;
    logic [52:0] s_try;
    logic [21:0] ln_q16, c_q16;
    logic [33:0] uf;
    logic signed [38:0] sc_w;
    logic signed [ScoreW-1:0] sc;
    logic take;
    logic pop, done;

    // Shared restoring divider step
    always_comb begin
        rem_sh = {r_rem, r_dvd[63]};
        rem_df = rem_sh - {1'b0, r_dvs};
        q_bit  = (rem_sh >= {1'b0, r_dvs});
        q_next = {r_dvd[62:0], q_bit};
    end

    always_comb begin
        a_val  = 29'(i_c_base) + ((29'(r_it.pv) + 29'd1) << 8);
        b_val  = (i_c_base == '0) ? 24'd1 : i_c_base;
        mq     = r_prod[61:30];
        s_try  = r_sr + r_sb;
        ln_q16 = 22'((58'(r_lnp) + (58'd1 << 35)) >> 36);
        c_q16  = ln_q16 + 22'(i_c_init);
        uf     = 34'((50'(r_uq) + (50'd1 << (FracW - 1))) >> (32 - FracW));
        sc_w   = (r_it.neg ? $signed({2'b00, r_mean}) : -$signed({2'b00, r_mean}))
                 + $signed({5'b0, uf});
        if (sc_w > 39'sd2147483647) begin
            sc = 32'sh7fffffff;
        end else if (sc_w < -39'sd2147483648) begin
            sc = 32'sh80000000;
        end else begin
            sc = sc_w[31:0];
        end
        take = !r_open || (sc > r_best);
    end

    // Sequencer
    always_comb begin
        n_st = r_st;   n_it = r_it;   n_cnt = r_cnt;
        n_dvd = r_dvd; n_rem = r_rem; n_dvs = r_dvs;
        n_r = r_r;     n_m = r_m;     n_prod = r_prod;
        n_ip = r_ip;   n_frac = r_frac; n_lnp = r_lnp; n_cp = r_cp;
        n_sx = r_sx;   n_sr = r_sr;   n_sb = r_sb;   n_s = r_s;
        n_mean = r_mean; n_uq = r_uq;
        n_best = r_best; n_bact = r_bact; n_open = r_open;
        n_ovalid = r_ovalid && !o_res.ready;
        n_oact = r_oact; n_oscore = r_oscore;
        pop = 1'b0; done = 1'b0;

        unique case (r_st)
            S_IDLE: begin
                if (!i_stat.empty) begin
                    pop   = 1'b1;
                    n_it  = i_head;
                    n_dvd = 64'(i_head.mag);
                    n_rem = '0;
                    n_dvs = i_head.n_zero ? 24'd1 : 24'(i_head.n);
                    n_cnt = '0;
                    n_st  = S_MEAN;
                end
            end
            S_MEAN: begin
                n_dvd = q_next;
                n_rem = q_bit ? rem_df[23:0] : rem_sh[23:0];
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    n_mean = r_it.n_zero ? '0 : q_next[36:0];
                    n_dvd  = {3'b0, a_val, 32'b0};
                    n_rem  = '0;
                    n_dvs  = b_val;
                    n_st   = S_LNDIV;
                end
            end
            S_LNDIV: begin
                n_dvd = q_next;
                n_rem = q_bit ? rem_df[23:0] : rem_sh[23:0];
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    n_cnt = '0;
                    if (q_next[63:32] == '0) begin
                        n_lnp = '0;
                        n_st  = S_CP;
                    end else begin
                        n_r  = q_next;
                        n_st = S_NORM;
                    end
                end
            end
            S_NORM: begin
                // shift until the top bit is set
                if (r_r[63]) begin
                    n_m    = r_r[63:33];
                    n_ip   = 5'd31 - r_cnt[4:0];
                    n_frac = '0;
                    n_cnt  = '0;
                    n_st   = S_SQ;
                end else begin
                    n_r   = {r_r[62:0], 1'b0};
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_SQ: begin
                n_prod = 62'(r_m) * 62'(r_m);
                n_st   = S_SQN;
            end
            S_SQN: begin
                n_frac = {r_frac[18:0], mq[31]};
                n_m    = mq[31] ? mq[31:1] : mq[30:0];
                if (r_cnt == 6'd19) begin
                    n_cnt = '0;
                    n_st  = S_LNMUL;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                    n_st  = S_SQ;
                end
            end
            S_LNMUL: begin
                n_lnp = 57'({r_ip, r_frac}) * 57'(LN2_Q32);
                n_st  = S_CP;
            end
            S_CP: begin
                n_cp  = 23'((39'(c_q16) * 39'(r_it.prior)) >> 16);
                n_sx  = 53'(r_it.pv) << 32;
                n_sr  = '0;
                n_sb  = 53'd1 << 50;
                n_cnt = '0;
                n_st  = S_SQRT;
            end
            S_SQRT: begin
                if (r_sx >= s_try) begin
                    n_sx = r_sx - s_try;
                    n_sr = (r_sr >> 1) + r_sb;
                end else begin
                    n_sr = r_sr >> 1;
                end
                n_sb  = r_sb >> 2;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd25) begin
                    n_s  = n_sr[25:0];
                    n_st = S_UMUL;
                end
            end
            S_UMUL: begin
                n_dvd = 64'(49'(r_cp) * 49'(r_s));
                n_rem = '0;
                n_dvs = 24'(r_it.n) + 24'd1;
                n_cnt = '0;
                n_st  = S_UDIV;
            end
            S_UDIV: begin
                n_dvd = q_next;
                n_rem = q_bit ? rem_df[23:0] : rem_sh[23:0];
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    n_uq = q_next[48:0];
                    n_st = S_SCORE;
                end
            end
            S_SCORE: begin
                // hold while the last child's result has no room
                if (!(r_it.last && r_ovalid && !o_res.ready)) begin
                    n_best = take ? sc : r_best;
                    n_bact = take ? r_it.action : r_bact;
                    n_open = !r_it.last;
                    if (r_it.last) begin
                        done     = 1'b1;
                        n_ovalid = 1'b1;
                        n_oact   = take ? r_it.action : r_bact;
                        n_oscore = take ? sc : r_best;
                    end
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_cnt    <= '0;
            r_best   <= '0;
            r_bact   <= '0;
            r_open   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_cnt    <= n_cnt;
            r_best   <= n_best;
            r_bact   <= n_bact;
            r_open   <= n_open;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_it <= n_it;   r_dvd <= n_dvd; r_rem <= n_rem; r_dvs <= n_dvs;
        r_r <= n_r;     r_m <= n_m;     r_prod <= n_prod;
        r_ip <= n_ip;   r_frac <= n_frac; r_lnp <= n_lnp; r_cp <= n_cp;
        r_sx <= n_sx;   r_sr <= n_sr;   r_sb <= n_sb;   r_s <= n_s;
        r_mean <= n_mean; r_uq <= n_uq;
        r_oact <= n_oact; r_oscore <= n_oscore;
    end

    assign o_bk.pop          = pop;
    assign o_bk.done         = done;
    assign o_res.valid       = r_ovalid;
    assign o_res.best_action = r_oact;
    assign o_res.best_score  = r_oscore;

endmodule

/* src/puct_child_selector.sv */
// ----------------------------------------------------------------------------
// PUCT child selector
// Streams the children of one node, scores each and returns the best action
// and score on the beat marked as the last child.
// ----------------------------------------------------------------------------
//  channel   dir   beat
//  i_in      in    one child: visits, action, value, prior, last flag
//  o_res     out   winning action and score, after a last child
//  i_cfg     in    register write: index and data
//
//  Each child in the back end takes three passes of the one-bit-a-cycle
//  divider, a normalising shift, 20 squarings and 26 square-root steps;
//  the logarithm steps are skipped when the ratio is below one.
//  A two-entry queue lets the front end take children while one is scored.
//  Reset is synchronous; no memory needs a clearing pass.
//  A result waits in the output register; the next last child stalls only
//  if that beat is still not taken.
`include "puct_child_selector_assert.svh"

module puct_child_selector (
    input  logic  i_clk,
    input  logic  i_rst_n,
    pcs_in_if.sink    i_in,
    pcs_out_if.source o_res,
    pcs_cfg_if.sink   i_cfg
);
    import pcs_pkg::*;

    logic [BaseW-1:0] r_c_base;
    logic [InitW-1:0] r_c_init;
    t_item      head;
    t_q_stat    q_stat;
    t_back_stat bk_stat;

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_base <= C_BASE_RST;
            r_c_init <= C_INIT_RST;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == REG_C_BASE) begin
                r_c_base <= i_cfg.data;
            end
            if (i_cfg.index == REG_C_INIT) begin
                r_c_init <= i_cfg.data[InitW-1:0];
            end
        end
    end

    pcs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_bk    (bk_stat),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    pcs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_stat   (q_stat),
        .i_c_base (r_c_base),
        .i_c_init (r_c_init),
        .o_bk     (bk_stat),
        .o_res    (o_res)
    );

    `PCS_ASSERT_IMP(a_full_stalls_in, i_clk, i_rst_n, q_stat.full, !i_in.ready, "beat taken with queue full")
    `PCS_ASSERT_IMP(a_pop_has_item, i_clk, i_rst_n, bk_stat.pop, !q_stat.empty, "pop from empty queue")
    `PCS_ASSERT_NXT(a_done_shows_res, i_clk, i_rst_n, bk_stat.done, o_res.valid, "result not presented")

endmodule
